// ===== hw/rtl/gcop_pkg.sv =====
// gcop_pkg: shared widths, fixed-point constants and the CORDIC arctangent
// table for the great-circle offset point pipeline.
// No dependencies.
`timescale 1ns / 1ps

package gcop_pkg;

  // CORDIC iteration count limits
  localparam int STAGE_CAP          = 40;
  localparam int CORDIC_STAGES_DEF  = 30;

  // datapath widths (30 fraction bits everywhere)
  localparam int RW   = 34;   // rotation CORDIC x, y and angle
  localparam int VW   = 40;   // vectoring CORDIC x, y
  localparam int ZW   = 36;   // vectoring CORDIC angle
  localparam int SQW  = 64;   // square root remainder and root
  localparam int SQ_STEPS = 32; // one result bit per step

  // configuration register indexes
  localparam logic [7:0] CFG_COS_OFFSET = 8'd0;
  localparam logic [7:0] CFG_SIN_OFFSET = 8'd1;

  // constants in Q.30
  localparam logic signed [35:0] ONE_Q30      = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [35:0] LAT_LIMIT    = 36'sd843314857;

  localparam logic [30:0] COS_OFFSET_RST = 31'd1073741824;
  localparam logic [30:0] SIN_OFFSET_RST = 31'd4752;

  // truncated atan(2^-i) in Q.30
  localparam logic [29:0] ATAN_TAB [STAGE_CAP] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
  };

endpackage

// ===== hw/rtl/great_circle_offset_point_top.sv =====
// great_circle_offset_point_top: pipelined great-circle offset point.
// Depends on gcop_pkg, gcop_rot_stage, gcop_sqrt_stage, gcop_vec_stage.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+-------------------------------
//   s_*      | in  | s_tvalid / s_tready   | s_tdata: heading, lat, lon
//   m_*      | out | m_tvalid / m_tready   | m_tdata: result lat, lon
//   cfg_*    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle enters while the pipeline is not held; the stages are
// input register, rotation CORDIC, five multiply stages, 32 square root
// steps, vectoring CORDIC, output register.
// Reset (rst, synchronous) clears the valid bits and loads the registers.
// The whole pipeline holds while a result waits on m_tready; nothing is
// lost or repeated. cfg_ready is always high.
`timescale 1ns / 1ps

module great_circle_offset_point_top import gcop_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] heading_angle, [62:32] start_latitude, [94:63] start_longitude
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [30:0] result_latitude, [62:31] result_longitude
  output logic [63:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int N = CORDIC_STAGES;
  localparam int SQ_SW = 32 + VW + 36 + 32;

  logic en;
  logic [30:0] cos_offset_angle, sin_offset_angle;
  logic signed [31:0] cd, sd;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign cd = $signed({1'b0, cos_offset_angle});
  assign sd = $signed({1'b0, sin_offset_angle});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_offset_angle <= COS_OFFSET_RST;
      sin_offset_angle <= SIN_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COS_OFFSET: cos_offset_angle <= cfg_data;
        CFG_SIN_OFFSET: sin_offset_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: double to Q.30 and fold into +-pi/2
  logic signed [35:0] hd_w, lat_w, hd_f, lat_f;
  logic neg_h_w, neg_l_w;

  always_comb begin
    hd_w  = $signed({{3{s_tdata[31]}}, s_tdata[31:0], 1'b0});
    lat_w = $signed({{4{s_tdata[62]}}, s_tdata[62:32], 1'b0});
    hd_f = hd_w;
    neg_h_w = 1'b0;
    if (hd_w > HALF_PI_Q30) begin
      hd_f = hd_w - PI_Q30;
      neg_h_w = 1'b1;
    end else if (hd_w < -HALF_PI_Q30) begin
      hd_f = hd_w + PI_Q30;
      neg_h_w = 1'b1;
    end
    lat_f = lat_w;
    neg_l_w = 1'b0;
    if (lat_w > HALF_PI_Q30) begin
      lat_f = lat_w - PI_Q30;
      neg_l_w = 1'b1;
    end else if (lat_w < -HALF_PI_Q30) begin
      lat_f = lat_w + PI_Q30;
      neg_l_w = 1'b1;
    end
  end

  // rotation CORDIC chains, heading and latitude side by side
  logic                 rv_h [0:N];
  logic                 rv_l [0:N];
  logic signed [RW-1:0] rx_h [0:N];
  logic signed [RW-1:0] ry_h [0:N];
  logic signed [RW-1:0] rz_h [0:N];
  logic signed [RW-1:0] rx_l [0:N];
  logic signed [RW-1:0] ry_l [0:N];
  logic signed [RW-1:0] rz_l [0:N];
  logic [0:0]           rs_h [0:N];
  logic [32:0]          rs_l [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv_h[0] <= 1'b0;
      rv_l[0] <= 1'b0;
    end else if (en) begin
      rv_h[0] <= s_tvalid;
      rv_l[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_h[0] <= RW'(INV_GAIN_Q30);
      ry_h[0] <= '0;
      rz_h[0] <= RW'(hd_f);
      rs_h[0] <= neg_h_w;
      rx_l[0] <= RW'(INV_GAIN_Q30);
      ry_l[0] <= '0;
      rz_l[0] <= RW'(lat_f);
      rs_l[0] <= {neg_l_w, s_tdata[94:63]};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    gcop_rot_stage #(.SHIFT(i), .SW(1)) u_rot_h (
      .clk(clk), .rst(rst), .en(en), .in_valid(rv_h[i]),
      .x_in(rx_h[i]), .y_in(ry_h[i]), .z_in(rz_h[i]), .side_in(rs_h[i]),
      .out_valid(rv_h[i+1]), .x_out(rx_h[i+1]), .y_out(ry_h[i+1]),
      .z_out(rz_h[i+1]), .side_out(rs_h[i+1])
    );
    gcop_rot_stage #(.SHIFT(i), .SW(33)) u_rot_l (
      .clk(clk), .rst(rst), .en(en), .in_valid(rv_l[i]),
      .x_in(rx_l[i]), .y_in(ry_l[i]), .z_in(rz_l[i]), .side_in(rs_l[i]),
      .out_valid(rv_l[i+1]), .x_out(rx_l[i+1]), .y_out(ry_l[i+1]),
      .z_out(rz_l[i+1]), .side_out(rs_l[i+1])
    );
  end

  // undo the fold; the bearing is heading + pi, so its sine and cosine flip
  logic signed [RW-1:0] sb_w, cb_w, slat_w, clat_w;
  logic signed [65:0]   p1_w, p2_w, p3_w;

  always_comb begin
    sb_w   = rs_h[N][0] ? ry_h[N] : -ry_h[N];
    cb_w   = rs_h[N][0] ? rx_h[N] : -rx_h[N];
    slat_w = rs_l[N][32] ? -ry_l[N] : ry_l[N];
    clat_w = rs_l[N][32] ? -rx_l[N] : rx_l[N];
    p1_w = 66'(slat_w) * 66'(cd);
    p2_w = 66'(clat_w) * 66'(sd);
    p3_w = 66'(sb_w) * 66'(sd);
  end

  // multiply stage 1
  logic m1_valid;
  logic signed [35:0] m1_p1, m1_p2, m1_p3;
  logic signed [RW-1:0] m1_slat, m1_clat, m1_cb;
  logic [31:0] m1_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= rv_l[N] && rv_h[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1   <= $signed(p1_w[65:30]);
      m1_p2   <= $signed(p2_w[65:30]);
      m1_p3   <= $signed(p3_w[65:30]);
      m1_slat <= slat_w;
      m1_clat <= clat_w;
      m1_cb   <= cb_w;
      m1_lon  <= rs_l[N][31:0];
    end
  end

  // multiply stage 2
  logic signed [69:0] p4_w, yl_w;
  assign p4_w = 70'(m1_p2) * 70'(m1_cb);
  assign yl_w = 70'(m1_p3) * 70'(m1_clat);

  logic m2_valid;
  logic signed [35:0] m2_p1, m2_p4, m2_ylon;
  logic signed [RW-1:0] m2_slat;
  logic [31:0] m2_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_p1   <= m1_p1;
      m2_p4   <= $signed(p4_w[65:30]);
      m2_ylon <= $signed(yl_w[65:30]);
      m2_slat <= m1_slat;
      m2_lon  <= m1_lon;
    end
  end

  // stage 3: asin argument, saturated to +-1
  logic signed [36:0] arg_sum;
  logic signed [31:0] arg_w;

  always_comb begin
    arg_sum = 37'(m2_p1) + 37'(m2_p4);
    if (arg_sum > 37'(ONE_Q30)) begin
      arg_w = 32'(ONE_Q30);
    end else if (arg_sum < -37'(ONE_Q30)) begin
      arg_w = -32'(ONE_Q30);
    end else begin
      arg_w = 32'(arg_sum);
    end
  end

  logic m3_valid;
  logic signed [31:0] m3_arg;
  logic signed [35:0] m3_ylon;
  logic signed [RW-1:0] m3_slat;
  logic [31:0] m3_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (en) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_arg  <= arg_w;
      m3_ylon <= m2_ylon;
      m3_slat <= m2_slat;
      m3_lon  <= m2_lon;
    end
  end

  // stage 4: arg squared and sin(lat) * arg
  logic signed [63:0] argsq_w;
  logic signed [65:0] sm_w;
  assign argsq_w = 64'(m3_arg) * 64'(m3_arg);
  assign sm_w    = 66'(m3_slat) * 66'(m3_arg);

  logic m4_valid;
  logic [63:0] m4_argsq;
  logic signed [35:0] m4_sm, m4_ylon;
  logic signed [31:0] m4_arg;
  logic [31:0] m4_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else if (en) begin
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_argsq <= argsq_w;
      m4_sm    <= $signed(sm_w[65:30]);
      m4_ylon  <= m3_ylon;
      m4_arg   <= m3_arg;
      m4_lon   <= m3_lon;
    end
  end

  // stage 5: radicand 1 - arg^2 and the longitude x term
  logic m5_valid;
  logic [SQW-1:0] m5_rad;
  logic signed [VW-1:0] m5_xlon;
  logic signed [35:0] m5_ylon;
  logic signed [31:0] m5_arg;
  logic [31:0] m5_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_valid <= 1'b0;
    end else if (en) begin
      m5_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_rad  <= (SQW'(1) << 60) - SQW'(m4_argsq);
      m5_xlon <= VW'(cd) - VW'(m4_sm);
      m5_ylon <= m4_ylon;
      m5_arg  <= m4_arg;
      m5_lon  <= m4_lon;
    end
  end

  // square root chain
  logic           qv [0:SQ_STEPS];
  logic [SQW-1:0] qrem [0:SQ_STEPS];
  logic [SQW-1:0] qroot [0:SQ_STEPS];
  logic [SQ_SW-1:0] qs [0:SQ_STEPS];

  assign qv[0]    = m5_valid;
  assign qrem[0]  = m5_rad;
  assign qroot[0] = '0;
  assign qs[0]    = {m5_arg, m5_xlon, m5_ylon, m5_lon};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    gcop_sqrt_stage #(.K(k), .SW(SQ_SW)) u_sqrt (
      .clk(clk), .rst(rst), .en(en), .in_valid(qv[k]),
      .v_in(qrem[k]), .r_in(qroot[k]), .side_in(qs[k]),
      .out_valid(qv[k+1]), .v_out(qrem[k+1]), .r_out(qroot[k+1]),
      .side_out(qs[k+1])
    );
  end

  // vectoring setup: zero vector flag, mirror of a negative x
  logic signed [31:0]   q_arg;
  logic signed [VW-1:0] q_xlon, q_ylon, q_cx, vx_lon0, vy_lon0;
  logic signed [ZW-1:0] vz_lon0;
  logic [31:0]          q_lon;
  logic                 zero_lat, zero_lon;

  always_comb begin
    q_arg  = $signed(qs[SQ_STEPS][SQ_SW-1 -: 32]);
    q_xlon = $signed(qs[SQ_STEPS][68 +: VW]);
    q_ylon = VW'($signed(qs[SQ_STEPS][32 +: 36]));
    q_lon  = qs[SQ_STEPS][31:0];
    q_cx   = $signed(VW'(qroot[SQ_STEPS][31:0]));
    zero_lat = (q_arg == 0) && (q_cx == 0);
    zero_lon = (q_xlon == 0) && (q_ylon == 0);
    vx_lon0 = q_xlon;
    vy_lon0 = q_ylon;
    vz_lon0 = '0;
    if (q_xlon < 0) begin
      vx_lon0 = -q_xlon;
      vy_lon0 = -q_ylon;
      vz_lon0 = (q_ylon >= 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
    end
  end

  // vectoring CORDIC chains, latitude and longitude side by side
  logic                 vv_l [0:N];
  logic                 vv_o [0:N];
  logic signed [VW-1:0] vx_l [0:N];
  logic signed [VW-1:0] vy_l [0:N];
  logic signed [ZW-1:0] vz_l [0:N];
  logic signed [VW-1:0] vx_o [0:N];
  logic signed [VW-1:0] vy_o [0:N];
  logic signed [ZW-1:0] vz_o [0:N];
  logic [0:0]           vs_l [0:N];
  logic [32:0]          vs_o [0:N];

  assign vv_l[0] = qv[SQ_STEPS];
  assign vv_o[0] = qv[SQ_STEPS];
  assign vx_l[0] = q_cx;
  assign vy_l[0] = VW'(q_arg);
  assign vz_l[0] = '0;
  assign vs_l[0] = zero_lat;
  assign vx_o[0] = vx_lon0;
  assign vy_o[0] = vy_lon0;
  assign vz_o[0] = vz_lon0;
  assign vs_o[0] = {zero_lon, q_lon};

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcop_vec_stage #(.SHIFT(i), .SW(1)) u_vec_l (
      .clk(clk), .rst(rst), .en(en), .in_valid(vv_l[i]),
      .x_in(vx_l[i]), .y_in(vy_l[i]), .z_in(vz_l[i]), .side_in(vs_l[i]),
      .out_valid(vv_l[i+1]), .x_out(vx_l[i+1]), .y_out(vy_l[i+1]),
      .z_out(vz_l[i+1]), .side_out(vs_l[i+1])
    );
    gcop_vec_stage #(.SHIFT(i), .SW(33)) u_vec_o (
      .clk(clk), .rst(rst), .en(en), .in_valid(vv_o[i]),
      .x_in(vx_o[i]), .y_in(vy_o[i]), .z_in(vz_o[i]), .side_in(vs_o[i]),
      .out_valid(vv_o[i+1]), .x_out(vx_o[i+1]), .y_out(vy_o[i+1]),
      .z_out(vz_o[i+1]), .side_out(vs_o[i+1])
    );
  end

  // output stage: back to Q3.29, clamp latitude, saturate longitude
  logic signed [ZW:0] zl, zo, rl, ro;
  logic signed [ZW:0] rlon_sum;
  logic signed [30:0] rlat_w;
  logic signed [31:0] rlon_w;

  always_comb begin
    zl = vs_l[N][0] ? '0 : (ZW+1)'(vz_l[N]);
    zo = vs_o[N][32] ? '0 : (ZW+1)'(vz_o[N]);
    rl = (zl + 1) >>> 1;
    ro = (zo + 1) >>> 1;
    if (rl > (ZW+1)'(LAT_LIMIT)) begin
      rlat_w = 31'(LAT_LIMIT);
    end else if (rl < -(ZW+1)'(LAT_LIMIT)) begin
      rlat_w = -31'(LAT_LIMIT);
    end else begin
      rlat_w = 31'(rl);
    end
    rlon_sum = (ZW+1)'($signed(vs_o[N][31:0])) + ro;
    if (rlon_sum > (ZW+1)'(32'sh7FFFFFFF)) begin
      rlon_w = 32'sh7FFFFFFF;
    end else if (rlon_sum < -(ZW+1)'(33'sh080000000)) begin
      rlon_w = 32'sh80000000;
    end else begin
      rlon_w = 32'(rlon_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vv_l[N] && vv_o[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, rlon_w, rlat_w};
    end
  end

endmodule

// ===== hw/rtl/gcop_rot_stage.sv =====
// gcop_rot_stage: one registered rotation-mode CORDIC iteration.
// Depends on gcop_pkg.
`timescale 1ns / 1ps

module gcop_rot_stage import gcop_pkg::*; #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [RW-1:0] x_in,
  input  logic signed [RW-1:0] y_in,
  input  logic signed [RW-1:0] z_in,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [RW-1:0] x_out,
  output logic signed [RW-1:0] y_out,
  output logic signed [RW-1:0] z_out,
  output logic [SW-1:0]        side_out
);

  logic signed [RW-1:0] tab;
  logic signed [RW-1:0] x_next, y_next, z_next;

  // rotate toward zero residual angle
  always_comb begin
    tab = $signed({{(RW-30){1'b0}}, ATAN_TAB[SHIFT]});
    if (z_in >= 0) begin
      x_next = x_in - (y_in >>> SHIFT);
      y_next = y_in + (x_in >>> SHIFT);
      z_next = z_in - tab;
    end else begin
      x_next = x_in + (y_in >>> SHIFT);
      y_next = y_in - (x_in >>> SHIFT);
      z_next = z_in + tab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

// ===== hw/rtl/gcop_vec_stage.sv =====
// gcop_vec_stage: one registered vectoring-mode CORDIC iteration.
// Depends on gcop_pkg.
`timescale 1ns / 1ps

module gcop_vec_stage import gcop_pkg::*; #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [VW-1:0] x_out,
  output logic signed [VW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SW-1:0]        side_out
);

  logic signed [ZW-1:0] tab;
  logic signed [VW-1:0] x_next, y_next;
  logic signed [ZW-1:0] z_next;

  // drive y toward zero, collect the angle
  always_comb begin
    tab = $signed({{(ZW-30){1'b0}}, ATAN_TAB[SHIFT]});
    if (y_in < 0) begin
      x_next = x_in - (y_in >>> SHIFT);
      y_next = y_in + (x_in >>> SHIFT);
      z_next = z_in - tab;
    end else begin
      x_next = x_in + (y_in >>> SHIFT);
      y_next = y_in - (x_in >>> SHIFT);
      z_next = z_in + tab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

// ===== hw/rtl/gcop_sqrt_stage.sv =====
// gcop_sqrt_stage: one registered step of the digit-by-digit integer
// square root, one result bit per stage. Depends on gcop_pkg.
`timescale 1ns / 1ps

module gcop_sqrt_stage import gcop_pkg::*; #(
  parameter int K  = 0,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [SQW-1:0] v_in,
  input  logic [SQW-1:0] r_in,
  input  logic [SW-1:0]  side_in,
  output logic           out_valid,
  output logic [SQW-1:0] v_out,
  output logic [SQW-1:0] r_out,
  output logic [SW-1:0]  side_out
);

  localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - K));

  logic [SQW-1:0] trial, v_next, r_next;

  // try the current bit pair
  always_comb begin
    trial = r_in + BIT;
    if (v_in >= trial) begin
      v_next = v_in - trial;
      r_next = (r_in >> 1) + BIT;
    end else begin
      v_next = v_in;
      r_next = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= v_next;
      r_out    <= r_next;
      side_out <= side_in;
    end
  end

endmodule

// ===== hw/rtl/gcop_checker.sv =====
// gcop_port_checker: port-level assertions for the offset point pipeline,
// bound to great_circle_offset_point_top. Depends on gcop_pkg.
`timescale 1ns / 1ps

module gcop_port_checker import gcop_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // pipeline advances exactly when the output stage can move
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  // no result right after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // latitude always clamped to +-pi/2
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:0]) <= 31'sd843314857 &&
                  $signed(m_tdata[30:0]) >= -31'sd843314857))
    else $error("result latitude out of range");

  // stalled result holds
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind great_circle_offset_point_top gcop_port_checker u_gcop_port_checker (.*);

// ===== tb/gcop_checker.sv =====
// gcop_checker: watches the request, result and register channels of the
// great-circle offset point block, predicts each result and compares it.
// Depends on gcop_pkg for register indexes and fixed-point constants.
`timescale 1ns / 1ps

module gcop_checker import gcop_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [30:0] lat;
  } offset_point_t;

  longint cos_d, sin_d;
  offset_point_t expected_points[$];

  // floor shift
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // rotation CORDIC: sine and cosine of a Q.30 angle
  task automatic rotate_sincos(input longint ang, output longint s, output longint c);
    longint x, y, nx;
    bit flip;
    x = INV_GAIN_Q30;
    y = 0;
    flip = 0;
    if (ang > HALF_PI_Q30) begin
      ang -= PI_Q30;
      flip = 1;
    end else if (ang < -HALF_PI_Q30) begin
      ang += PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < STAGE_CAP; i++) begin
      if (ang >= 0) begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        ang -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        ang += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  // vectoring CORDIC: atan2 in Q.30
  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < STAGE_CAP; i++) begin
      if (y < 0) begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_offset_point(input logic [95:0] req, output offset_point_t p);
    longint hd, lat, lon, sh, ch, slat, clat, arg, cx, zlat, ylon, xlon, rlat, rlon;
    hd = longint'(signed'(req[31:0])) * 2;
    lat = longint'(signed'(req[62:32])) * 2;
    lon = longint'(signed'(req[94:63]));
    rotate_sincos(hd, sh, ch);
    rotate_sincos(lat, slat, clat);
    // bearing reversed: sin and cos negated
    arg = qmul(slat, cos_d) + qmul(qmul(clat, sin_d), -ch);
    if (arg > ONE_Q30) arg = ONE_Q30;
    if (arg < -ONE_Q30) arg = -ONE_Q30;
    cx = longint'(int_sqrt(longint'(ONE_Q30) * ONE_Q30 - arg * arg));
    zlat = vector_angle(arg, cx);
    rlat = (zlat + 1) >>> 1;
    if (rlat > LAT_LIMIT) rlat = LAT_LIMIT;
    if (rlat < -LAT_LIMIT) rlat = -LAT_LIMIT;
    ylon = qmul(qmul(-sh, sin_d), clat);
    xlon = cos_d - qmul(slat, arg);
    rlon = lon + ((vector_angle(ylon, xlon) + 1) >>> 1);
    if (rlon > 64'sd2147483647) rlon = 64'sd2147483647;
    if (rlon < -64'sd2147483648) rlon = -64'sd2147483648;
    p.lat = rlat[30:0];
    p.lon = rlon[31:0];
  endtask

  assign pending = expected_points.size();

  always @(posedge clk) begin
    offset_point_t p, got;
    if (rst) begin
      cos_d <= longint'(COS_OFFSET_RST);
      sin_d <= longint'(SIN_OFFSET_RST);
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COS_OFFSET) cos_d <= longint'(cfg_data);
        else if (cfg_index == CFG_SIN_OFFSET) sin_d <= longint'(cfg_data);
      end
      if (s_tvalid && s_tready) begin
        predict_offset_point(s_tdata, p);
        expected_points.push_back(p);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[62:0];
        if (expected_points.size() == 0) begin
          if (fail_count < 10) $display("unexpected result lat %0d lon %0d", got.lat, got.lon);
          fail_count <= fail_count + 1;
        end else begin
          p = expected_points.pop_front();
          if (p.lat !== got.lat || p.lon !== got.lon) begin
            if (fail_count < 10)
              $display("mismatch: lat exp %0d got %0d, lon exp %0d got %0d",
                       p.lat, got.lat, p.lon, got.lon);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives requests, register writes and back-pressure into
// great_circle_offset_point_top; gcop_checker predicts and compares results.
// Depends on gcop_pkg, gcop_checker and the block's RTL.
`timescale 1ns / 1ps

module testbench import gcop_pkg::*;;

  localparam int LATENCY = 2 * CORDIC_STAGES_DEF + 39;
  localparam longint LAT_MAX = 843314857;
  localparam longint LON_MAX = 1686629713;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [95:0] s_tdata = '0;
  logic [63:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = CFG_COS_OFFSET;
  logic [30:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;

  always #6 clk = ~clk;

  great_circle_offset_point_top uut (.*);
  gcop_checker checker_i (.*);

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // s_tvalid stays high after a request; the next idle cycle or the
  // caller drops it
  task automatic send_request(logic [31:0] hd, logic [30:0] lat, logic [31:0] lon);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, lon, lat, hd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_register(logic [7:0] idx, logic [30:0] val);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_range(longint lim);
    return 32'(longint'($urandom_range(2 * lim)) - lim);
  endfunction

  task automatic send_random();
    logic [31:0] hd, lat, lon;
    hd = $urandom();
    lat = rand_range(LAT_MAX);
    lon = rand_range(LON_MAX);
    case ($urandom_range(7))
      0: lat = $urandom_range(1) ? 32'(LAT_MAX) : -32'(LAT_MAX);
      1: lon = $urandom_range(1) ? 32'(LON_MAX) : -32'(LON_MAX);
      2: hd = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: ;
    endcase
    send_request(hd, lat[30:0], lon);
  endtask

  initial begin
    int cos_vals[5], sin_vals[5];
    cos_vals = '{1073741824, 0, 760000000, 1073741824, 1073741824};
    sin_vals = '{1073741824, 1073741824, 760000000, 0, 4752};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes at reset register values
    send_request(0, 0, 0);
    send_request(32'h7fffffff, 31'(LAT_MAX), 32'(LON_MAX));
    send_request(32'h80000000, -31'(LAT_MAX), -32'(LON_MAX));
    send_request(32'h7fffffff, -31'(LAT_MAX), 32'(LON_MAX));
    send_request(32'h80000000, 31'(LAT_MAX), -32'(LON_MAX));
    send_request(32'd843314857, 0, 32'(LON_MAX));
    send_request(-32'd843314857, 0, -32'(LON_MAX));
    send_request(32'd1686629713, 31'd421657428, 0);
    send_request(32'hffffffff, 31'h7fffffff, 32'hffffffff);
    // several register settings, each stepping through all four idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      write_register(CFG_COS_OFFSET, 31'(cos_vals[ph]));
      write_register(CFG_SIN_OFFSET, 31'(sin_vals[ph]));
      send_request(32'h7fffffff, 31'(LAT_MAX), 32'(LON_MAX));
      send_request(0, 31'(LAT_MAX), 32'h7fffffff);
      send_request(32'h80000000, -31'(LAT_MAX), 32'h80000000);
      for (int n = 0; n < 340; n++) begin
        if (n % 85 == 0) begin
          case ((n / 85 + ph) % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 62; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 62; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
          endcase
        end
        if (ph == 2 && n == 100) fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
        send_random();
      end
    end
    // random register values, including the largest allowed
    write_register(CFG_COS_OFFSET, 31'h7fffffff);
    write_register(CFG_SIN_OFFSET, 31'($urandom_range(1073741824)));
    recv_stall_pct = 0;
    for (int n = 0; n < 20; n++) send_random();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("great_circle_offset_point_top verification clean");
    else $display("great_circle_offset_point_top verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("great_circle_offset_point_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gcop_pkg.sv
hw/rtl/gcop_rot_stage.sv
hw/rtl/gcop_vec_stage.sv
hw/rtl/gcop_sqrt_stage.sv
hw/rtl/great_circle_offset_point_top.sv
hw/rtl/gcop_checker.sv
tb/gcop_checker.sv
tb/testbench.sv
